>>> design/lbvs_pkg.sv
// ----------------------------------------------------------------------------
// lbvs_pkg: shared types and constants for the vertex skinning unit
// operation codes, register indexes, result kinds and fixed-point constants
// ----------------------------------------------------------------------------
package lbvs_pkg;

   typedef logic [1:0]  op_type;
   typedef logic [2:0]  csr_idx_type;
   typedef logic [47:0] vec3_type;

   // operation codes of an input word
   localparam op_type OP_WRITE = 2'd0;
   localparam op_type OP_SKIN  = 2'd1;
   localparam op_type OP_END   = 2'd2;

   // register indexes of the csr port
   localparam csr_idx_type CSR_ANIMATE    = 3'd0;
   localparam csr_idx_type CSR_BONE_COUNT = 3'd1;
   localparam csr_idx_type CSR_SCALE      = 3'd2;
   localparam csr_idx_type CSR_OFFSET_X   = 3'd3;
   localparam csr_idx_type CSR_OFFSET_Y   = 3'd4;
   localparam csr_idx_type CSR_OFFSET_Z   = 3'd5;

   // result kinds
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_BOUNDS = 1'b1;

   // matrix layout and fixed-point constants
   localparam int          MAT_WORDS = 12;
   localparam logic [17:0] WSUM_MIN  = 18'd7;
   localparam logic [31:0] Q16_ONE   = 32'd65536;
   localparam logic signed [15:0] BOX_MIN_RESET = 16'sh7fff;
   localparam logic signed [15:0] BOX_MAX_RESET = 16'sh8000;

endpackage

>>> design/linear_blend_vertex_skinning_unit.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_unit
// four-influence linear blend skinning with placement, normalize and bounds
// ----------------------------------------------------------------------------
//
// channel  direction  handshake              word
// req      in         req_valid/req_ready    palette write, vertex or end of mesh
// rsp      out        rsp_valid/rsp_ready    skinned vertex or bounding box
// csr      in         csr_valid/csr_ready    register index and write data
//
// one word is worked on at a time; req_ready is high only while the sequencer idles.
// a palette write or ignored op leaves the sequencer idle; end of mesh goes through the emit state.
// a vertex runs blend per used influence, scale, placement and two normalize passes, paced
// by the single shared 33x33 multiplier, the one-bit-a-cycle square root and the
// restoring divider.
// the bone palette memory needs no clearing pass; reset is synchronous, active high.
// a result waits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_unit #(
   parameter int MAX_BONES  = 64,
   parameter int INFLUENCES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lbvs_pkg::op_type      req_operation,
   input  lbvs_pkg::vec3_type    req_rest_position,
   input  lbvs_pkg::vec3_type    req_rest_normal,
   input  lbvs_pkg::vec3_type    req_rest_tangent,
   input  logic [63:0]           req_influence_weights,
   input  logic [31:0]           req_influence_bones,
   input  logic [6:0]            req_palette_slot,
   input  logic [3:0]            req_palette_element,
   input  logic signed [31:0]    req_palette_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_result_kind,
   output lbvs_pkg::vec3_type    rsp_world_position,
   output lbvs_pkg::vec3_type    rsp_world_normal,
   output lbvs_pkg::vec3_type    rsp_world_tangent,
   output lbvs_pkg::vec3_type    rsp_bounds_min,
   output lbvs_pkg::vec3_type    rsp_bounds_max,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  lbvs_pkg::csr_idx_type csr_index,
   input  logic [31:0]           csr_data
);
   import lbvs_pkg::*;

   localparam int PAL_DEPTH = MAX_BONES * MAT_WORDS;
   localparam int ADDR_W    = $clog2(PAL_DEPTH);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_BSEL   = 4'd1;
   localparam logic [3:0] ST_BLEND  = 4'd2;
   localparam logic [3:0] ST_MIX    = 4'd3;
   localparam logic [3:0] ST_SCALE  = 4'd4;
   localparam logic [3:0] ST_PLACE  = 4'd5;
   localparam logic [3:0] ST_NLOAD  = 4'd6;
   localparam logic [3:0] ST_NSHIFT = 4'd7;
   localparam logic [3:0] ST_NSQ    = 4'd8;
   localparam logic [3:0] ST_NSQRT  = 4'd9;
   localparam logic [3:0] ST_NDIV   = 4'd10;
   localparam logic [3:0] ST_EMIT   = 4'd11;

   localparam logic [49:0] NORM_LO = 50'd1 << 22;
   localparam logic [49:0] NORM_HI = 50'd1 << 23;

   // saturate to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // saturate to signed Q8.8
   function automatic logic signed [15:0] sat16(input logic signed [43:0] v);
      if (v > 44'sd32767) begin
         return 16'sh7fff;
      end else if (v < -44'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // round a Q.32 blend sum to Q.16 and saturate
   function automatic logic signed [31:0] mix_round(input logic signed [63:0] acc);
      logic signed [63:0] t;
      t = acc + 64'sd32768;
      return sat32($signed(t[63:16]));
   endfunction

   // divider start value: magnitude * 256 + s / 2
   function automatic logic [32:0] div_start(input logic [22:0] a, input logic [23:0] s);
      return {2'b00, a, 8'b0} + {10'b0, s[23:1]};
   endfunction

   // control and configuration
   logic [3:0]         state_ff;
   logic [1:0]         ph_ff;
   logic [1:0]         j_ff;
   logic [1:0]         va_ff;
   logic [1:0]         c_ff;
   logic [2:0]         r_ff;
   logic               nq_ff;
   logic               kind_ff;
   logic               animate_ff;
   logic [6:0]         bone_count_ff;
   logic [31:0]        scale_ff;
   logic signed [15:0] off_ff [3];
   logic signed [31:0] pm_ff [MAT_WORDS];
   logic signed [15:0] bmin_ff [3];
   logic signed [15:0] bmax_ff [3];

   // vertex working registers
   logic signed [15:0] vin_ff [3][3];
   logic [63:0]        w_ff;
   logic [31:0]        b_ff;
   logic [17:0]        wsum_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic signed [51:0] lin_ff;
   logic signed [43:0] l_ff;
   logic signed [63:0] acc_ff [3][3];
   logic signed [31:0] v32_ff [3][3];
   logic signed [31:0] d_ff;
   logic signed [50:0] sum_ff;
   logic signed [15:0] wp_ff [3];
   logic signed [49:0] nv_ff [2][3];

   // normalize registers
   logic [49:0]        am_ff [3];
   logic               neg_ff [3];
   logic [49:0]        mx_ff;
   logic [47:0]        l2_ff;
   logic [48:0]        sq_v_ff;
   logic [48:0]        sq_res_ff;
   logic [48:0]        sq_bit_ff;
   logic [23:0]        s_ff;
   logic [32:0]        rem_ff;
   logic [3:0]         k_ff;
   logic [8:0]         q_ff;
   logic [47:0]        nout_ff [2];

   // output register
   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [47:0]        rsp_pos_ff;
   logic [47:0]        rsp_nrm_ff;
   logic [47:0]        rsp_tan_ff;
   logic [47:0]        rsp_bmin_ff;
   logic [47:0]        rsp_bmax_ff;

   // palette memory
   logic [31:0]        pal_mem [PAL_DEPTH];
   logic [31:0]        mem_q_ff;
   logic [ADDR_W-1:0]  pal_raddr;
   logic [11:0]        pal_waddr_full;
   logic               pal_we;
   logic               pm_we;

   // shared multiplier
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] prod_ff;

   logic               req_fire;
   logic [15:0]        w_cur;
   logic [7:0]         bi_cur;
   logic               inf_used;
   logic               last_inf;
   logic signed [51:0] lin_rnd;
   logic signed [65:0] prod_rnd16;
   logic signed [49:0] prod_q16;
   logic signed [33:0] sc_diff;
   logic signed [31:0] pm_q;
   logic signed [51:0] pl_sum;
   logic signed [15:0] pl_wp;
   logic [49:0]        nl_abs [3];
   logic               nl_neg [3];
   logic [49:0]        nl_max;
   logic [49:0]        sq_trial;
   logic               sq_ge;
   logic [32:0]        div_trial;
   logic               div_ge;
   logic [8:0]         div_q_next;
   logic [15:0]        div_comp;
   logic               use_blend;
   logic               emit_go;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   // palette write decode
   assign pal_waddr_full = {5'b0, req_palette_slot} * 12'(MAT_WORDS)
                         + {8'b0, req_palette_element};
   assign pal_we = req_fire && (req_operation == OP_WRITE)
                && (req_palette_element < 4'(MAT_WORDS))
                && ({2'b0, req_palette_slot} < 9'(MAX_BONES));
   assign pm_we  = req_fire && (req_operation == OP_WRITE)
                && (req_palette_element < 4'(MAT_WORDS))
                && ({2'b0, req_palette_slot} == 9'(MAX_BONES));
   assign pal_raddr = base_ff + ADDR_W'(r_ff[1:0] * 3 + c_ff);

   // palette memory; a word is to be read only after it was written, which the block does not enforce
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_waddr_full[ADDR_W-1:0]] <= req_palette_value;
      end
      mem_q_ff <= pal_mem[pal_raddr];
   end

   // influence selection
   assign w_cur    = w_ff[16*j_ff +: 16];
   assign bi_cur   = b_ff[8*j_ff +: 8];
   assign inf_used = (w_cur != 16'd0) && ({1'b0, bi_cur} < {2'b0, bone_count_ff})
                  && ({1'b0, bi_cur} < 9'(MAX_BONES));
   assign last_inf = (j_ff == 2'(INFLUENCES - 1));
   assign use_blend = animate_ff && (wsum_ff >= WSUM_MIN);

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_BLEND: begin
            if (r_ff < 3'd3) begin
               mul_a = 33'(vin_ff[va_ff][r_ff[1:0]]);
               mul_b = 33'($signed(mem_q_ff));
            end else if (r_ff == 3'd3) begin
               mul_a = (va_ff == 2'd0) ? 33'sd256 : 33'sd0;
               mul_b = 33'($signed(mem_q_ff));
            end else if (r_ff == 3'd4) begin
               mul_a = $signed({{11{l_ff[43]}}, l_ff[43:22]});
               mul_b = $signed({17'b0, w_cur});
            end else begin
               mul_a = $signed({11'b0, l_ff[21:0]});
               mul_b = $signed({17'b0, w_cur});
            end
         end
         ST_SCALE: begin
            mul_a = 33'(d_ff);
            mul_b = $signed({1'b0, scale_ff});
         end
         ST_PLACE: begin
            mul_a = 33'(v32_ff[va_ff][r_ff[1:0]]);
            mul_b = 33'(pm_q);
         end
         ST_NSQ: begin
            mul_a = $signed({10'b0, am_ff[c_ff][22:0]});
            mul_b = $signed({10'b0, am_ff[c_ff][22:0]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // rounding and saturation helpers
   assign lin_rnd    = lin_ff + 52'sd128;
   assign prod_rnd16 = prod_ff + 66'sd32768;
   assign prod_q16   = $signed(prod_rnd16[65:16]);
   assign sc_diff    = 34'(v32_ff[0][c_ff]) - 34'($signed({off_ff[c_ff], 8'b0}));
   assign pm_q       = pm_ff[4'(r_ff[1:0] * 3 + c_ff)];
   assign pl_sum     = 52'(sum_ff) + 52'(pm_q) + 52'sd128;
   assign pl_wp      = sat16($signed(pl_sum[51:8]));

   // magnitudes for normalize
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nl_neg[i] = nv_ff[nq_ff][i][49];
         nl_abs[i] = nl_neg[i] ? 50'(-nv_ff[nq_ff][i]) : 50'(nv_ff[nq_ff][i]);
      end
      nl_max = nl_abs[0];
      if (nl_abs[1] > nl_max) begin
         nl_max = nl_abs[1];
      end
      if (nl_abs[2] > nl_max) begin
         nl_max = nl_abs[2];
      end
   end

   // square root and divider steps
   assign sq_trial   = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};
   assign sq_ge      = ({1'b0, sq_v_ff} >= sq_trial);
   assign div_trial  = 33'(s_ff) << k_ff;
   assign div_ge     = (rem_ff >= div_trial);
   assign div_q_next = q_ff | (div_ge ? (9'd1 << k_ff) : 9'd0);
   assign div_comp   = neg_ff[c_ff] ? (16'd0 - {7'b0, div_q_next}) : {7'b0, div_q_next};
   assign emit_go    = !rsp_valid_ff || rsp_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         animate_ff    <= 1'b0;
         bone_count_ff <= '0;
         scale_ff      <= Q16_ONE;
         for (int i = 0; i < 3; i++) begin
            off_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ANIMATE:    animate_ff    <= csr_data[0];
            CSR_BONE_COUNT: bone_count_ff <= csr_data[6:0];
            CSR_SCALE:      scale_ff      <= csr_data;
            CSR_OFFSET_X:   off_ff[0]     <= csr_data[15:0];
            CSR_OFFSET_Y:   off_ff[1]     <= csr_data[15:0];
            CSR_OFFSET_Z:   off_ff[2]     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // placement matrix, identity after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_WORDS; i++) begin
            pm_ff[i] <= (i == 0 || i == 4 || i == 8) ? $signed(Q16_ONE) : 32'sd0;
         end
      end else if (pm_we) begin
         pm_ff[req_palette_element] <= req_palette_value;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= '0;
         j_ff         <= '0;
         va_ff        <= '0;
         c_ff         <= '0;
         r_ff         <= '0;
         nq_ff        <= 1'b0;
         kind_ff      <= KIND_VERTEX;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            bmin_ff[i] <= BOX_MIN_RESET;
            bmax_ff[i] <= BOX_MAX_RESET;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            // accept a word
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_operation == OP_SKIN) begin
                     for (int i = 0; i < 3; i++) begin
                        vin_ff[0][i] <= req_rest_position[16*i +: 16];
                        vin_ff[1][i] <= req_rest_normal[16*i +: 16];
                        vin_ff[2][i] <= req_rest_tangent[16*i +: 16];
                        for (int k = 0; k < 3; k++) begin
                           acc_ff[i][k] <= '0;
                        end
                     end
                     w_ff    <= req_influence_weights;
                     b_ff    <= req_influence_bones;
                     wsum_ff <= '0;
                     j_ff    <= '0;
                     kind_ff <= KIND_VERTEX;
                     state_ff <= animate_ff ? ST_BSEL : ST_MIX;
                  end else if (req_operation == OP_END) begin
                     kind_ff  <= KIND_BOUNDS;
                     state_ff <= ST_EMIT;
                  end
               end
            end
            // pick the next used influence
            ST_BSEL: begin
               if (inf_used) begin
                  wsum_ff  <= wsum_ff + {2'b0, w_cur};
                  base_ff  <= ADDR_W'({4'b0, bi_cur} * 12'(MAT_WORDS));
                  va_ff    <= '0;
                  c_ff     <= '0;
                  r_ff     <= '0;
                  ph_ff    <= '0;
                  state_ff <= ST_BLEND;
               end else if (last_inf) begin
                  state_ff <= ST_MIX;
               end else begin
                  j_ff <= j_ff + 2'd1;
               end
            end
            // bone matrix products, then weight products
            ST_BLEND: begin
               ph_ff <= (ph_ff == 2'd2) ? 2'd0 : ph_ff + 2'd1;
               if (r_ff == 3'd4 && ph_ff == 2'd0) begin
                  l_ff <= lin_rnd[51:8];
               end
               if (ph_ff == 2'd2) begin
                  if (r_ff < 3'd4) begin
                     lin_ff <= ((r_ff == 3'd0) ? 52'sd0 : lin_ff) + $signed(prod_ff[51:0]);
                     r_ff   <= r_ff + 3'd1;
                  end else if (r_ff == 3'd4) begin
                     acc_ff[va_ff][c_ff] <= acc_ff[va_ff][c_ff]
                                          + $signed({prod_ff[41:0], 22'b0});
                     r_ff <= 3'd5;
                  end else begin
                     acc_ff[va_ff][c_ff] <= acc_ff[va_ff][c_ff] + $signed(prod_ff[63:0]);
                     r_ff <= '0;
                     if (c_ff == 2'd2) begin
                        c_ff <= '0;
                        if (va_ff == 2'd2) begin
                           va_ff <= '0;
                           if (last_inf) begin
                              state_ff <= ST_MIX;
                           end else begin
                              j_ff     <= j_ff + 2'd1;
                              state_ff <= ST_BSEL;
                           end
                        end else begin
                           va_ff <= va_ff + 2'd1;
                        end
                     end else begin
                        c_ff <= c_ff + 2'd1;
                     end
                  end
               end
            end
            // blended or raw attributes in Q16.16
            ST_MIX: begin
               for (int i = 0; i < 3; i++) begin
                  for (int k = 0; k < 3; k++) begin
                     v32_ff[i][k] <= use_blend ? mix_round(acc_ff[i][k])
                                               : 32'($signed({vin_ff[i][k], 8'b0}));
                  end
               end
               c_ff     <= '0;
               ph_ff    <= '0;
               state_ff <= ST_SCALE;
            end
            // offset and uniform scale of the position
            ST_SCALE: begin
               ph_ff <= (ph_ff == 2'd2) ? 2'd0 : ph_ff + 2'd1;
               if (ph_ff == 2'd0) begin
                  d_ff <= sat32(sc_diff);
               end
               if (ph_ff == 2'd2) begin
                  v32_ff[0][c_ff] <= sat32(prod_q16);
                  if (c_ff == 2'd2) begin
                     c_ff     <= '0;
                     va_ff    <= '0;
                     r_ff     <= '0;
                     state_ff <= ST_PLACE;
                  end else begin
                     c_ff <= c_ff + 2'd1;
                  end
               end
            end
            // placement matrix, per-product rounding
            ST_PLACE: begin
               if (r_ff < 3'd3) begin
                  ph_ff <= (ph_ff == 2'd2) ? 2'd0 : ph_ff + 2'd1;
                  if (ph_ff == 2'd2) begin
                     sum_ff <= ((r_ff == 3'd0) ? 51'sd0 : sum_ff) + 51'(prod_q16);
                     r_ff   <= r_ff + 3'd1;
                  end
               end else begin
                  if (va_ff == 2'd0) begin
                     wp_ff[c_ff] <= pl_wp;
                     if (pl_wp < bmin_ff[c_ff]) begin
                        bmin_ff[c_ff] <= pl_wp;
                     end
                     if (pl_wp > bmax_ff[c_ff]) begin
                        bmax_ff[c_ff] <= pl_wp;
                     end
                  end else begin
                     nv_ff[va_ff == 2'd2][c_ff] <= sum_ff[49:0];
                  end
                  r_ff <= '0;
                  if (c_ff == 2'd2) begin
                     c_ff <= '0;
                     if (va_ff == 2'd2) begin
                        nq_ff    <= 1'b0;
                        state_ff <= ST_NLOAD;
                     end else begin
                        va_ff <= va_ff + 2'd1;
                     end
                  end else begin
                     c_ff <= c_ff + 2'd1;
                  end
               end
            end
            // normalize: magnitudes, zero vector gives zero
            ST_NLOAD: begin
               for (int i = 0; i < 3; i++) begin
                  am_ff[i]  <= nl_abs[i];
                  neg_ff[i] <= nl_neg[i];
               end
               mx_ff <= nl_max;
               if (nl_max == 50'd0) begin
                  nout_ff[nq_ff] <= '0;
                  if (nq_ff) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     nq_ff <= 1'b1;
                  end
               end else begin
                  state_ff <= ST_NSHIFT;
               end
            end
            // bring the largest magnitude into [2^22, 2^23)
            ST_NSHIFT: begin
               if (mx_ff >= NORM_HI) begin
                  for (int i = 0; i < 3; i++) begin
                     am_ff[i] <= am_ff[i] >> 1;
                  end
                  mx_ff <= mx_ff >> 1;
               end else if (mx_ff < NORM_LO) begin
                  for (int i = 0; i < 3; i++) begin
                     am_ff[i] <= am_ff[i] << 1;
                  end
                  mx_ff <= mx_ff << 1;
               end else begin
                  l2_ff    <= '0;
                  c_ff     <= '0;
                  ph_ff    <= '0;
                  state_ff <= ST_NSQ;
               end
            end
            // sum of squares
            ST_NSQ: begin
               ph_ff <= (ph_ff == 2'd2) ? 2'd0 : ph_ff + 2'd1;
               if (ph_ff == 2'd2) begin
                  l2_ff <= l2_ff + prod_ff[47:0];
                  if (c_ff == 2'd2) begin
                     sq_v_ff   <= {1'b0, l2_ff} + {1'b0, prod_ff[47:0]};
                     sq_res_ff <= '0;
                     sq_bit_ff <= 49'd1 << 48;
                     state_ff  <= ST_NSQRT;
                  end else begin
                     c_ff <= c_ff + 2'd1;
                  end
               end
            end
            // integer square root, one result bit a cycle
            ST_NSQRT: begin
               if (sq_bit_ff == 49'd0) begin
                  s_ff     <= sq_res_ff[23:0];
                  rem_ff   <= div_start(am_ff[0][22:0], sq_res_ff[23:0]);
                  k_ff     <= 4'd8;
                  q_ff     <= '0;
                  c_ff     <= '0;
                  state_ff <= ST_NDIV;
               end else begin
                  if (sq_ge) begin
                     sq_v_ff   <= 49'({1'b0, sq_v_ff} - sq_trial);
                     sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
                  end else begin
                     sq_res_ff <= sq_res_ff >> 1;
                  end
                  sq_bit_ff <= sq_bit_ff >> 2;
               end
            end
            // restoring divide, one quotient bit a cycle
            ST_NDIV: begin
               if (k_ff == 4'd0) begin
                  nout_ff[nq_ff][16*c_ff +: 16] <= div_comp;
                  if (c_ff == 2'd2) begin
                     c_ff <= '0;
                     if (nq_ff) begin
                        state_ff <= ST_EMIT;
                     end else begin
                        nq_ff    <= 1'b1;
                        state_ff <= ST_NLOAD;
                     end
                  end else begin
                     c_ff   <= c_ff + 2'd1;
                     rem_ff <= div_start(am_ff[c_ff + 2'd1][22:0], s_ff);
                     k_ff   <= 4'd8;
                     q_ff   <= '0;
                  end
               end else begin
                  if (div_ge) begin
                     rem_ff <= rem_ff - div_trial;
                  end
                  q_ff <= div_q_next;
                  k_ff <= k_ff - 4'd1;
               end
            end
            // load the output register once it is free
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= kind_ff;
                  if (kind_ff == KIND_VERTEX) begin
                     rsp_pos_ff  <= {wp_ff[2], wp_ff[1], wp_ff[0]};
                     rsp_nrm_ff  <= nout_ff[0];
                     rsp_tan_ff  <= nout_ff[1];
                     rsp_bmin_ff <= '0;
                     rsp_bmax_ff <= '0;
                  end else begin
                     rsp_pos_ff  <= '0;
                     rsp_nrm_ff  <= '0;
                     rsp_tan_ff  <= '0;
                     rsp_bmin_ff <= {bmin_ff[2], bmin_ff[1], bmin_ff[0]};
                     rsp_bmax_ff <= {bmax_ff[2], bmax_ff[1], bmax_ff[0]};
                     for (int i = 0; i < 3; i++) begin
                        bmin_ff[i] <= BOX_MIN_RESET;
                        bmax_ff[i] <= BOX_MAX_RESET;
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_world_position = rsp_pos_ff;
   assign rsp_world_normal   = rsp_nrm_ff;
   assign rsp_world_tangent  = rsp_tan_ff;
   assign rsp_bounds_min     = rsp_bmin_ff;
   assign rsp_bounds_max     = rsp_bmax_ff;

   // squares are taken only on a normalized vector
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NSQ) |-> (mx_ff >= NORM_LO && mx_ff < NORM_HI))
      else $error("normalize range lost before sum of squares");

   // the divisor is never zero
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NDIV) |-> (s_ff != 24'd0))
      else $error("zero divisor in normalize");

   // a unit component never exceeds one
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NDIV && k_ff == 4'd0) |-> (div_q_next <= 9'd256))
      else $error("normalize quotient above one");

endmodule
